[rtl/sse_pkg.sv]
// Shared types, constants and rounding helper for the spectral efficiency estimator.
package sse_pkg;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	localparam logic [18:0] K_Q20   = 19'd348330;
	localparam logic [29:0] LN2_Q30 = 30'd744260924;

	localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
	localparam logic signed [33:0] T_HALF  = 34'sd536870912;
	localparam logic signed [33:0] T_SIXTH = 34'sd178957329;
	localparam logic [31:0]        T_24TH  = 32'd44739601;

	localparam logic signed [33:0] L_C0 = -34'sd1870236959;
	localparam logic signed [33:0] L_C1 = 34'sd3029243226;
	localparam logic signed [33:0] L_C2 = -34'sd1578354096;
	localparam logic signed [33:0] L_C3 = 34'sd480155386;
	localparam logic [31:0]        L_C4_MAG = 32'd60742489;

	localparam logic [25:0] OUT_MAX = 26'h3FFFFFF;

	typedef struct packed {
		logic        neg;
		logic [5:0]  xi;
		logic [29:0] fr;
		logic [15:0] bw;
	} work_t;

	function automatic logic [33:0] rnd_q30(input logic [63:0] prod);
		logic [64:0] sum;
		sum = {1'b0, prod} + 65'd536870912;
		return sum[63:30];
	endfunction

endpackage

[rtl/sse_fifo.sv]
// Small register queue with combinational head read.
module sse_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full) else $error("write into full queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("queue count out of range");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> cnt_q == CW'($past(cnt_q) + 1'b1))
		else $error("queue count did not advance");
	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_rd && !do_wr) |=> cnt_q == CW'($past(cnt_q) - 1'b1))
		else $error("queue count did not retire");

endmodule

[rtl/sse_front.sv]
// Front stage: takes a transaction and splits the scaled SNR into exponent parts.
module sse_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [15:0]   snr_db,
	input  logic [15:0]   bandwidth,
	output logic          q_wr,
	input  logic          q_full,
	output sse_pkg::work_t q_data
);
	logic           vld_s1;
	sse_pkg::work_t work_s1;
	logic           neg_c;
	logic [15:0]    abs_c;
	logic [34:0]    mag_c;

	assign full   = vld_s1 && q_full;
	assign q_wr   = vld_s1 && !q_full;
	assign q_data = work_s1;

	always_comb begin
		neg_c = snr_db[15];
		abs_c = neg_c ? (~snr_db + 16'd1) : snr_db;
		mag_c = {19'd0, abs_c} * {16'd0, sse_pkg::K_Q20};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!full) begin
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			work_s1.neg <= neg_c;
			work_s1.xi  <= mag_c[33:28];
			work_s1.fr  <= {mag_c[27:0], 2'b00};
			work_s1.bw  <= bandwidth;
		end
	end

endmodule

[rtl/sse_back.sv]
// Back pipeline: exponential, normalization, log2 polynomial and bandwidth scaling.
module sse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_rd,
	input  sse_pkg::work_t q_data,
	output logic           o_wr,
	input  logic           o_full,
	output logic [25:0]    o_data
);
	localparam int NS = 17;

	logic [NS:1] vld_q;
	logic        en;

	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [5:0]  xi_s1, xi_s2, xi_s3, xi_s4, xi_s5, xi_s6;
	logic [15:0] bw_dly_q [1:15];
	logic [59:0] pt_s1;
	logic [29:0] tm_s2, tm_s3, tm_s4;
	logic [61:0] pr_s2, pr_s3, pr_s4, pr_s5;
	logic [31:0] r_s6;
	logic [62:0] y_s7, y_s8, y_s9;
	logic [2:0]  grp_s8;
	logic [5:0]  p_s9, p_s10, p_s11, p_s12, p_s13, p_s14;
	logic [30:0] m_s10, m_s11, m_s12, m_s13;
	logic [62:0] pa_s11, pa_s12, pa_s13, pa_s14;
	logic        sg_s11, sg_s12, sg_s13, sg_s14;
	logic [35:0] lg_s15;
	logic [51:0] cp_s16;
	logic [25:0] cap_s17;

	logic [29:0]        tm_c;
	logic signed [33:0] r3_c, r4_c, r5_c, r6_c;
	logic [63:0]        ratio_c;
	logic [62:0]        y_c;
	logic [2:0]         grp_c;
	logic [2:0]         bit_c;
	logic [7:0]         byte_c;
	logic [62:0]        z_c;
	logic signed [33:0] a12_c, a13_c, a14_c, a15_c;
	logic signed [37:0] lgs_c;
	logic [5:0]         e_c;
	logic [52:0]        csum_c;

	assign en     = !(vld_q[NS] && o_full);
	assign q_rd   = en && q_valid;
	assign o_wr   = vld_q[NS] && !o_full;
	assign o_data = cap_s17;

	function automatic logic signed [33:0] apply_sg(input logic sg, input logic [33:0] q);
		return sg ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic [31:0] mag32(input logic signed [33:0] v);
		logic [33:0] u;
		u = v[33] ? 34'(-v) : 34'(v);
		return u[31:0];
	endfunction

	always_comb begin
		logic signed [6:0] k;
		logic [5:0]        s;
		logic [4:0]        sh;
		logic [63:0]       yp;
		logic [63:0]       yq;
		logic [33:0]       tr;

		tr   = sse_pkg::rnd_q30({4'd0, pt_s1});
		tm_c = tr[29:0];
		r3_c = sse_pkg::T_SIXTH + apply_sg(neg_s2, sse_pkg::rnd_q30({2'd0, pr_s2}));
		r4_c = sse_pkg::T_HALF  + apply_sg(neg_s3, sse_pkg::rnd_q30({2'd0, pr_s3}));
		r5_c = sse_pkg::Q30_ONE + apply_sg(neg_s4, sse_pkg::rnd_q30({2'd0, pr_s4}));
		r6_c = sse_pkg::Q30_ONE + apply_sg(neg_s5, sse_pkg::rnd_q30({2'd0, pr_s5}));

		k = neg_s6 ? -$signed({1'b0, xi_s6}) : $signed({1'b0, xi_s6});
		sh = 5'(k - 7'sd12);
		s  = 6'(7'sd12 - k);
		if (k >= 7'sd12) begin
			ratio_c = {32'd0, r_s6} << sh;
		end else begin
			ratio_c = ({32'd0, r_s6} + (64'd1 << (s - 6'd1))) >> s;
		end
		y_c = 63'd262144 + ratio_c[62:0];

		yp = {1'b0, y_s7};
		grp_c = '0;
		for (int i = 0; i < 8; i++) begin
			if (|yp[8*i +: 8]) begin
				grp_c = 3'(i);
			end
		end

		yq = {1'b0, y_s8};
		byte_c = yq[8*grp_s8 +: 8];
		bit_c = '0;
		for (int j = 0; j < 8; j++) begin
			if (byte_c[j]) begin
				bit_c = 3'(j);
			end
		end

		z_c = y_s9 << (6'd62 - p_s9);

		a12_c = sse_pkg::L_C3 + apply_sg(sg_s11, sse_pkg::rnd_q30({1'b0, pa_s11}));
		a13_c = sse_pkg::L_C2 + apply_sg(sg_s12, sse_pkg::rnd_q30({1'b0, pa_s12}));
		a14_c = sse_pkg::L_C1 + apply_sg(sg_s13, sse_pkg::rnd_q30({1'b0, pa_s13}));
		a15_c = sse_pkg::L_C0 + apply_sg(sg_s14, sse_pkg::rnd_q30({1'b0, pa_s14}));
		e_c   = p_s14 - 6'd18;
		lgs_c = $signed({2'b00, e_c, 30'd0}) + 38'(a15_c);

		csum_c = {1'b0, cp_s16} + 53'd33554432;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-1:1], q_rd};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= q_data.neg;
			xi_s1  <= q_data.xi;
			pt_s1  <= {30'd0, q_data.fr} * {30'd0, sse_pkg::LN2_Q30};
			bw_dly_q[1] <= q_data.bw;
			for (int i = 2; i <= 15; i++) begin
				bw_dly_q[i] <= bw_dly_q[i-1];
			end

			neg_s2 <= neg_s1; xi_s2 <= xi_s1;
			tm_s2  <= tm_c;
			pr_s2  <= {32'd0, tm_c} * {30'd0, sse_pkg::T_24TH};

			neg_s3 <= neg_s2; xi_s3 <= xi_s2; tm_s3 <= tm_s2;
			pr_s3  <= {32'd0, tm_s2} * {30'd0, r3_c[31:0]};

			neg_s4 <= neg_s3; xi_s4 <= xi_s3; tm_s4 <= tm_s3;
			pr_s4  <= {32'd0, tm_s3} * {30'd0, r4_c[31:0]};

			neg_s5 <= neg_s4; xi_s5 <= xi_s4;
			pr_s5  <= {32'd0, tm_s4} * {30'd0, r5_c[31:0]};

			neg_s6 <= neg_s5; xi_s6 <= xi_s5;
			r_s6   <= r6_c[33] ? 32'd0 : r6_c[31:0];

			y_s7   <= y_c;

			y_s8   <= y_s7;
			grp_s8 <= grp_c;

			y_s9   <= y_s8;
			p_s9   <= {grp_s8, bit_c};

			p_s10  <= p_s9;
			m_s10  <= z_c[62:32];

			p_s11  <= p_s10; m_s11 <= m_s10;
			pa_s11 <= {32'd0, m_s10} * {31'd0, sse_pkg::L_C4_MAG};
			sg_s11 <= 1'b1;

			p_s12  <= p_s11; m_s12 <= m_s11;
			pa_s12 <= {32'd0, m_s11} * {31'd0, mag32(a12_c)};
			sg_s12 <= a12_c[33];

			p_s13  <= p_s12; m_s13 <= m_s12;
			pa_s13 <= {32'd0, m_s12} * {31'd0, mag32(a13_c)};
			sg_s13 <= a13_c[33];

			p_s14  <= p_s13;
			pa_s14 <= {32'd0, m_s13} * {31'd0, mag32(a14_c)};
			sg_s14 <= a14_c[33];

			lg_s15 <= lgs_c[37] ? 36'd0 : lgs_c[35:0];

			cp_s16 <= {36'd0, bw_dly_q[15]} * {16'd0, lg_s15};

			cap_s17 <= (csum_c[52:26] > {1'b0, sse_pkg::OUT_MAX}) ?
				sse_pkg::OUT_MAX : csum_c[51:26];
		end
	end

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_q == $past(vld_q)) else $error("pipeline moved while stalled");
	a_pop_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> (q_valid && en)) else $error("queue read without advance");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NS] && en) |-> o_wr) else $error("result dropped at pipeline end");

endmodule

[rtl/shannon_spectral_efficiency.sv]
// Top level of the Shannon spectral efficiency estimator.
//
//   channel   direction  handshake            payload
//   input     in         push / full          snr_db, bandwidth
//   result    out        empty / pop          capacity_gbps
//
// One transaction per clock sustained while results are popped; a result passes the
// front register, work queue, 17-stage back pipeline and result queue in that order.
// Reset clears valid bits, queue pointers and queue counts only.
// A full result queue halts the whole back pipeline once a result sits in its last
// stage; the front keeps filling the work queue until it is full, then raises full.
module shannon_spectral_efficiency #(
	parameter int MID_DEPTH = sse_pkg::MID_DEPTH,
	parameter int OUT_DEPTH = sse_pkg::OUT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] snr_db,
	input  logic [15:0] bandwidth,
	output logic        empty,
	input  logic        pop,
	output logic [25:0] capacity_gbps
);
	logic           mq_wr;
	logic           mq_full;
	sse_pkg::work_t mq_wdata;
	logic           mq_rd;
	logic           mq_empty;
	sse_pkg::work_t mq_rdata;
	logic           oq_wr;
	logic           oq_full;
	logic [25:0]    oq_wdata;

	sse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.snr_db    (snr_db),
		.bandwidth (bandwidth),
		.q_wr      (mq_wr),
		.q_full    (mq_full),
		.q_data    (mq_wdata)
	);

	sse_fifo #(
		.WIDTH ($bits(sse_pkg::work_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mq_wr),
		.wr_data (mq_wdata),
		.full    (mq_full),
		.rd_en   (mq_rd),
		.rd_data (mq_rdata),
		.empty   (mq_empty)
	);

	sse_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (!mq_empty),
		.q_rd    (mq_rd),
		.q_data  (mq_rdata),
		.o_wr    (oq_wr),
		.o_full  (oq_full),
		.o_data  (oq_wdata)
	);

	sse_fifo #(
		.WIDTH (26),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (oq_wr),
		.wr_data (oq_wdata),
		.full    (oq_full),
		.rd_en   (pop),
		.rd_data (capacity_gbps),
		.empty   (empty)
	);

endmodule
